@@ hdl/mer_pkg.sv @@
// ============================================================================
// mer_pkg: shared types and constants of the midpoint ellipse rasterizer
// Field widths, datapath widths and the command/status bundles that pass
// between the controller and the datapath.
// ============================================================================
`default_nettype none

package mer_pkg;

    // Field widths of the stream payloads
    localparam int RAD_W    = 11;                 // semi-axis
    localparam int CRD_W    = 12;                 // centre coordinate
    localparam int PT_W     = 14;                 // output point coordinate
    localparam int S_DATA_W = 48;                 // 2*RAD_W + 2*CRD_W, byte padded
    localparam int M_DATA_W = 8 * PT_W;           // four points, x and y each

    // Datapath widths
    localparam int OFF_W  = 12;                   // offset from the centre
    localparam int SQ_W   = 2 * RAD_W;            // squared radius
    localparam int GRAD_W = 36;                   // gradient terms
    localparam int DEC_W  = 50;                   // decision value, scaled by 4
    localparam int MUL_W  = 26;                   // multiplier operand
    localparam int PROD_W = 2 * MUL_W;            // multiplier product

    // Operand pairs of the shared multiplier
    typedef enum logic [2:0] {
        MUL_RX_RX   = 3'd0,
        MUL_RY_RY   = 3'd1,
        MUL_RX2_RY  = 3'd2,
        MUL_OX_OX   = 3'd3,
        MUL_RY2_P   = 3'd4,
        MUL_YM_YM   = 3'd5,
        MUL_RX2_P   = 3'd6,
        MUL_RX2_RY2 = 3'd7
    } mul_sel_t;

    // Write-back of the registered product
    typedef enum logic [2:0] {
        WB_NONE = 3'd0,
        WB_RX2  = 3'd1,
        WB_RY2  = 3'd2,
        WB_INIT = 3'd3,
        WB_LOAD = 3'd4,
        WB_ADD4 = 3'd5,
        WB_SUB4 = 3'd6
    } wb_op_t;

    // Controller to datapath
    typedef struct packed {
        logic     load_start;   // latch radii and centre, start region one
        mul_sel_t mul_sel;
        wb_op_t   wb_op;
        logic     enter_r2;     // region two decision is in place
        logic     emit;         // load a point set into the output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic phase_done;
        logic phase_r1;
        logic grad_lt;          // grad_x < grad_y
        logic out_free;         // output register can take a new transaction
    } dp_status_t;

endpackage

`default_nettype wire

@@ hdl/midpoint_ellipse_rasterizer.sv @@
// ============================================================================
// midpoint_ellipse_rasterizer: two-region midpoint ellipse point generator
// Top level: stream ports, controller and datapath.
// ============================================================================
`default_nettype none

// A start transaction (s_tuser = 0) latches the radii and centre and returns
// the first set of four symmetric points; each step transaction (s_tuser = 1)
// returns the next set. The set at y offset zero in region two carries m_tlast;
// steps after it return a transaction with every field zero, m_tuser included.
// One transaction is in work at a time. A start passes three times through the
// shared 26x26 multiplier, plus setup, before its point set is emitted, and the
// transaction on which region two begins first runs the multiply sequence of
// its first decision value. A finished result waits in the output register
// while the next transaction is accepted.
module midpoint_ellipse_rasterizer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // radius_x[10:0], radius_y[21:11], centre_x[33:22], centre_y[45:34], zero pad
    input  wire logic [mer_pkg::S_DATA_W-1:0]  s_tdata,
    // cmd: 0 start, 1 step
    input  wire logic                          s_tuser,
    // Result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // pa_x, pa_y, pb_x, pb_y, pc_x, pc_y, pd_x, pd_y, 14 bits each from bit 0
    output logic [mer_pkg::M_DATA_W-1:0]       m_tdata,
    // point_valid
    output logic                               m_tuser,
    // last_set
    output logic                               m_tlast
);

    mer_pkg::dp_cmd_t    dp_cmd;
    mer_pkg::dp_status_t dp_status;

    // Sequencer
    mer_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    // Arithmetic and result register
    mer_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (dp_cmd),
        .status   (dp_status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // A new point set never overwrites one that is still pending
    ap_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.emit |-> dp_status.out_free)
        else $error("point set emitted into an occupied output register");

    // No region-one emit once the gradient condition has failed
    ap_r1_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.emit && dp_status.phase_r1) |-> dp_status.grad_lt)
        else $error("region one emit after the region change point");

    // One transaction in work at a time
    ap_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction accepted while one is in work");

    // The last set is always a valid set
    ap_last_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("last flag on an invalid point set");

endmodule

`default_nettype wire

@@ hdl/mer_datapath.sv @@
// ============================================================================
// mer_datapath: registers and arithmetic of the ellipse rasterizer
// Holds radii, centre, offsets, gradients and decision value, a shared
// 26x26 multiplier with registered product, and the result register.
// ============================================================================
`default_nettype none

module mer_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // radius_x, radius_y, centre_x, centre_y from bit 0 up
    input  wire logic [mer_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire mer_pkg::dp_cmd_t              cmd,
    output mer_pkg::dp_status_t                status,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    // pa_x, pa_y, pb_x, pb_y, pc_x, pc_y, pd_x, pd_y from bit 0 up
    output logic [mer_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                               m_tuser,   // point_valid
    output logic                               m_tlast    // last_set
);

    localparam int RAD_W  = mer_pkg::RAD_W;
    localparam int CRD_W  = mer_pkg::CRD_W;
    localparam int PT_W   = mer_pkg::PT_W;
    localparam int OFF_W  = mer_pkg::OFF_W;
    localparam int SQ_W   = mer_pkg::SQ_W;
    localparam int GRAD_W = mer_pkg::GRAD_W;
    localparam int DEC_W  = mer_pkg::DEC_W;
    localparam int MUL_W  = mer_pkg::MUL_W;
    localparam int PROD_W = mer_pkg::PROD_W;

    typedef enum logic [2:0] {
        PH_DONE = 3'b001,
        PH_R1   = 3'b010,
        PH_R2   = 3'b100
    } phase_t;

    logic [RAD_W-1:0]  rx_reg, rx_next, ry_reg, ry_next;
    logic [CRD_W-1:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic [OFF_W-1:0]  ox_reg, ox_next, oy_reg, oy_next;
    logic [GRAD_W-1:0] gx_reg, gx_next, gy_reg, gy_next;
    logic [DEC_W-1:0]  dec_reg, dec_next;
    logic [SQ_W-1:0]   rx2_reg, rx2_next, ry2_reg, ry2_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    phase_t            phase_reg, phase_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [PT_W*8-1:0]    m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;
    logic                 m_tlast_reg, m_tlast_next;

    // Multiplier operands
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [OFF_W:0]    odd_x;
    logic [OFF_W-1:0]  y_less;

    // Step terms
    logic [GRAD_W-1:0] gx_inc, gy_dec;
    logic [DEC_W-1:0]  prod_dec, prod_x4, sum_diag_r1, sum_diag_r2, sum_vert, sum_horz;
    logic              dec_neg, dec_pos, is_last;

    // Point coordinates
    logic [PT_W-1:0]   cx_ext, cy_ext, ox_ext, oy_ext;
    logic [PT_W-1:0]   x_plus, x_minus, y_plus, y_minus;

    // Operand selection for the shared multiplier
    assign odd_x  = {ox_reg, 1'b1};
    assign y_less = (oy_reg == '0) ? OFF_W'(1) : oy_reg - OFF_W'(1);

    always_comb begin
        case (cmd.mul_sel)
            mer_pkg::MUL_RX_RX: begin
                mul_a = MUL_W'(rx_reg);
                mul_b = MUL_W'(rx_reg);
            end
            mer_pkg::MUL_RY_RY: begin
                mul_a = MUL_W'(ry_reg);
                mul_b = MUL_W'(ry_reg);
            end
            mer_pkg::MUL_RX2_RY: begin
                mul_a = MUL_W'(rx2_reg);
                mul_b = MUL_W'(ry_reg);
            end
            mer_pkg::MUL_OX_OX: begin
                mul_a = MUL_W'(odd_x);
                mul_b = MUL_W'(odd_x);
            end
            mer_pkg::MUL_RY2_P: begin
                mul_a = MUL_W'(ry2_reg);
                mul_b = prod_reg[MUL_W-1:0];
            end
            mer_pkg::MUL_YM_YM: begin
                mul_a = MUL_W'(y_less);
                mul_b = MUL_W'(y_less);
            end
            mer_pkg::MUL_RX2_P: begin
                mul_a = MUL_W'(rx2_reg);
                mul_b = prod_reg[MUL_W-1:0];
            end
            mer_pkg::MUL_RX2_RY2: begin
                mul_a = MUL_W'(rx2_reg);
                mul_b = MUL_W'(ry2_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Step terms, all decision arithmetic modulo 2^DEC_W
    assign gx_inc   = gx_reg + GRAD_W'({ry2_reg, 1'b0});
    assign gy_dec   = gy_reg - GRAD_W'({rx2_reg, 1'b0});
    assign prod_dec = prod_reg[DEC_W-1:0];
    assign prod_x4  = {prod_reg[DEC_W-3:0], 2'b00};
    assign dec_neg  = dec_reg[DEC_W-1];
    assign dec_pos  = !dec_reg[DEC_W-1] && (dec_reg != '0);

    assign sum_horz    = DEC_W'(gx_inc) + DEC_W'(ry2_reg);
    assign sum_diag_r1 = DEC_W'(gx_inc) - DEC_W'(gy_dec) + DEC_W'(ry2_reg);
    assign sum_vert    = DEC_W'(rx2_reg) - DEC_W'(gy_dec);
    assign sum_diag_r2 = DEC_W'(gx_inc) - DEC_W'(gy_dec) + DEC_W'(rx2_reg);

    // Four symmetric points, wrapping to the output width
    assign cx_ext  = PT_W'(cx_reg);
    assign cy_ext  = PT_W'(cy_reg);
    assign ox_ext  = PT_W'(ox_reg);
    assign oy_ext  = PT_W'(oy_reg);
    assign x_plus  = cx_ext + ox_ext;
    assign x_minus = cx_ext - ox_ext;
    assign y_plus  = cy_ext + oy_ext;
    assign y_minus = cy_ext - oy_ext;

    assign is_last = (phase_reg == PH_R2) && (oy_reg == '0);

    // Next-state logic of the datapath registers
    always_comb begin
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        gx_next    = gx_reg;
        gy_next    = gy_reg;
        dec_next   = dec_reg;
        rx2_next   = rx2_reg;
        ry2_next   = ry2_reg;
        phase_next = phase_reg;

        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;

        // New ellipse
        if (cmd.load_start) begin
            rx_next    = s_tdata[RAD_W-1:0];
            ry_next    = s_tdata[2*RAD_W-1:RAD_W];
            cx_next    = s_tdata[2*RAD_W+CRD_W-1:2*RAD_W];
            cy_next    = s_tdata[2*RAD_W+2*CRD_W-1:2*RAD_W+CRD_W];
            ox_next    = '0;
            oy_next    = OFF_W'(s_tdata[2*RAD_W-1:RAD_W]);
            gx_next    = '0;
            phase_next = PH_R1;
        end

        // Product write-back
        case (cmd.wb_op)
            mer_pkg::WB_NONE: ;
            mer_pkg::WB_RX2:  rx2_next = prod_reg[SQ_W-1:0];
            mer_pkg::WB_RY2:  ry2_next = prod_reg[SQ_W-1:0];
            mer_pkg::WB_INIT: begin
                gy_next  = {prod_reg[GRAD_W-2:0], 1'b0};
                dec_next = DEC_W'({ry2_reg, 2'b00}) - prod_x4 + DEC_W'(rx2_reg);
            end
            mer_pkg::WB_LOAD: dec_next = prod_dec;
            mer_pkg::WB_ADD4: dec_next = dec_reg + prod_x4;
            mer_pkg::WB_SUB4: dec_next = dec_reg - prod_x4;
            default: ;
        endcase

        if (cmd.enter_r2) begin
            phase_next = PH_R2;
        end

        // Emit a point set and advance
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
            if (phase_reg == PH_DONE) begin
                m_tdata_next = '0;
                m_tuser_next = 1'b0;
                m_tlast_next = 1'b0;
            end else begin
                m_tdata_next = {y_plus, x_minus, y_minus, x_plus,
                                y_minus, x_minus, y_plus, x_plus};
                m_tuser_next = 1'b1;
                m_tlast_next = is_last;
                if (is_last) begin
                    phase_next = PH_DONE;
                end else if (phase_reg == PH_R1) begin
                    ox_next = ox_reg + OFF_W'(1);
                    gx_next = gx_inc;
                    if (dec_neg) begin
                        dec_next = dec_reg + {sum_horz[DEC_W-3:0], 2'b00};
                    end else begin
                        oy_next  = oy_reg - OFF_W'(1);
                        gy_next  = gy_dec;
                        dec_next = dec_reg + {sum_diag_r1[DEC_W-3:0], 2'b00};
                    end
                end else begin
                    oy_next = oy_reg - OFF_W'(1);
                    gy_next = gy_dec;
                    if (dec_pos) begin
                        dec_next = dec_reg + {sum_vert[DEC_W-3:0], 2'b00};
                    end else begin
                        ox_next  = ox_reg + OFF_W'(1);
                        gx_next  = gx_inc;
                        dec_next = dec_reg + {sum_diag_r2[DEC_W-3:0], 2'b00};
                    end
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_DONE;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        gx_reg      <= gx_next;
        gy_reg      <= gy_next;
        dec_reg     <= dec_next;
        rx2_reg     <= rx2_next;
        ry2_reg     <= ry2_next;
        prod_reg    <= prod_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    // Status back to the controller
    assign status.phase_done = (phase_reg == PH_DONE);
    assign status.phase_r1   = (phase_reg == PH_R1);
    assign status.grad_lt    = (gx_reg < gy_reg);
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

@@ hdl/mer_ctrl.sv @@
// ============================================================================
// mer_ctrl: sequencer of the ellipse rasterizer
// Accepts one transaction at a time, runs the multiply sequences for the
// start and for the region change, and triggers the emit of each point set.
// ============================================================================
`default_nettype none

module mer_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic                 s_tuser,    // cmd: 0 start, 1 step
    input  wire mer_pkg::dp_status_t  status,
    output mer_pkg::dp_cmd_t          cmd
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_MUL_RX = 12'b0000_0000_0010,
        ST_MUL_RY = 12'b0000_0000_0100,
        ST_MUL_T  = 12'b0000_0000_1000,
        ST_INIT   = 12'b0000_0001_0000,
        ST_EMIT   = 12'b0000_0010_0000,
        ST_R2_OX  = 12'b0000_0100_0000,
        ST_R2_RY2 = 12'b0000_1000_0000,
        ST_R2_YM  = 12'b0001_0000_0000,
        ST_R2_RX2 = 12'b0010_0000_0000,
        ST_R2_RR  = 12'b0100_0000_0000,
        ST_R2_FIN = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Next state and datapath commands
    always_comb begin
        state_next     = state_reg;
        cmd.load_start = 1'b0;
        cmd.mul_sel    = mer_pkg::MUL_RX_RX;
        cmd.wb_op      = mer_pkg::WB_NONE;
        cmd.enter_r2   = 1'b0;
        cmd.emit       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_tuser) begin
                        cmd.load_start = 1'b1;
                        state_next     = ST_MUL_RX;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            // rx^2, ry^2, rx^2*ry for the start values
            ST_MUL_RX: begin
                cmd.mul_sel = mer_pkg::MUL_RX_RX;
                state_next  = ST_MUL_RY;
            end
            ST_MUL_RY: begin
                cmd.wb_op   = mer_pkg::WB_RX2;
                cmd.mul_sel = mer_pkg::MUL_RY_RY;
                state_next  = ST_MUL_T;
            end
            ST_MUL_T: begin
                cmd.wb_op   = mer_pkg::WB_RY2;
                cmd.mul_sel = mer_pkg::MUL_RX2_RY;
                state_next  = ST_INIT;
            end
            ST_INIT: begin
                cmd.wb_op  = mer_pkg::WB_INIT;
                state_next = ST_EMIT;
            end
            // Region change first, else emit once the output is free
            ST_EMIT: begin
                if (status.phase_r1 && !status.grad_lt) begin
                    state_next = ST_R2_OX;
                end else if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            // Region two start: ry2*(2x+1)^2 + 4*rx2*(y-1)^2 - 4*rx2*ry2
            ST_R2_OX: begin
                cmd.mul_sel = mer_pkg::MUL_OX_OX;
                state_next  = ST_R2_RY2;
            end
            ST_R2_RY2: begin
                cmd.mul_sel = mer_pkg::MUL_RY2_P;
                state_next  = ST_R2_YM;
            end
            ST_R2_YM: begin
                cmd.wb_op   = mer_pkg::WB_LOAD;
                cmd.mul_sel = mer_pkg::MUL_YM_YM;
                state_next  = ST_R2_RX2;
            end
            ST_R2_RX2: begin
                cmd.mul_sel = mer_pkg::MUL_RX2_P;
                state_next  = ST_R2_RR;
            end
            ST_R2_RR: begin
                cmd.wb_op   = mer_pkg::WB_ADD4;
                cmd.mul_sel = mer_pkg::MUL_RX2_RY2;
                state_next  = ST_R2_FIN;
            end
            ST_R2_FIN: begin
                cmd.wb_op    = mer_pkg::WB_SUB4;
                cmd.enter_r2 = 1'b1;
                state_next   = ST_EMIT;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// ============================================================================
// tb_top: testbench of the midpoint ellipse rasterizer
// Streams start and step transactions into the block. Idle gaps on the input
// and stalls on the output are random. Each accepted transaction goes through
// a cycle-free model of the two-region midpoint walk, and every result
// transaction is compared field by field with the oldest predicted point set.
// ============================================================================
`default_nettype none

module tb_top;

    // Command carried in s_tuser
    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    // Walk phase of the model
    typedef enum logic [1:0] {
        PH_DONE = 2'd0,
        PH_R1   = 2'd1,
        PH_R2   = 2'd2
    } walk_phase_t;

    typedef struct packed {
        cmd_t                      cmd;
        logic [mer_pkg::RAD_W-1:0] rad_x;
        logic [mer_pkg::RAD_W-1:0] rad_y;
        logic [mer_pkg::CRD_W-1:0] ctr_x;
        logic [mer_pkg::CRD_W-1:0] ctr_y;
    } draw_req_t;

    // coord[0..7]: pa_x, pa_y, pb_x, pb_y, pc_x, pc_y, pd_x, pd_y
    typedef struct packed {
        logic [7:0][mer_pkg::PT_W-1:0] coord;
        logic                          valid;
        logic                          last;
    } point_set_t;

    localparam int    MAX_IDLE   = 8;
    localparam int    RAND_ITEMS = 700;
    localparam string COORD_NAME [8] = '{"pa_x", "pa_y", "pb_x", "pb_y",
                                         "pc_x", "pc_y", "pd_x", "pd_y"};

    // DUT interface
    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [mer_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic                         s_tuser = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [mer_pkg::M_DATA_W-1:0] m_tdata;
    logic                         m_tuser;
    logic                         m_tlast;

    // Stimulus and scoreboard
    draw_req_t  pending_reqs [$];
    point_set_t expected_sets [$];
    int         n_total    = 0;
    int         n_accepted = 0;
    int         n_errors   = 0;
    bit         in_fire    = 1'b0;
    bit         out_fire   = 1'b0;
    int         in_gap     = 0;
    int         out_stall  = 0;
    bit         in_calm    = 1'b0;
    bit         out_calm   = 1'b0;

    // Ellipse walk state
    int          off_x, off_y;
    logic [63:0] grad_x, grad_y, decision;
    logic [63:0] hold_rx, hold_ry;
    logic [mer_pkg::CRD_W-1:0] hold_cx, hold_cy;
    walk_phase_t walk_phase;

    midpoint_ellipse_rasterizer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock and reset
    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // Idle draw; calm stretches have no idling at all
    function automatic int draw_idle(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = ~calm;
        return calm ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // Emit the current point set, then advance the walk by one point
    function automatic point_set_t emit_set();
        point_set_t  ps;
        logic [63:0] rx2, ry2, ox, ym1;
        logic [mer_pkg::PT_W-1:0] cx, cy, dx, dy;
        rx2 = hold_rx * hold_rx;
        ry2 = hold_ry * hold_ry;
        // Region two begins where the x gradient catches up with the y gradient
        if (walk_phase == PH_R1 && !(grad_x < grad_y)) begin
            ym1 = longint'(off_y - 1);
            ox  = longint'(off_x);
            ox  = 2 * ox + 1;
            decision = ry2 * ox * ox + 4 * rx2 * ym1 * ym1 - 4 * rx2 * ry2;
            walk_phase = PH_R2;
        end
        cx = mer_pkg::PT_W'(hold_cx);
        cy = mer_pkg::PT_W'(hold_cy);
        dx = off_x[mer_pkg::PT_W-1:0];
        dy = off_y[mer_pkg::PT_W-1:0];
        ps.coord[0] = cx + dx;
        ps.coord[1] = cy + dy;
        ps.coord[2] = cx - dx;
        ps.coord[3] = cy - dy;
        ps.coord[4] = cx + dx;
        ps.coord[5] = cy - dy;
        ps.coord[6] = cx - dx;
        ps.coord[7] = cy + dy;
        ps.valid    = 1'b1;
        ps.last     = (walk_phase == PH_R2 && off_y == 0);
        if (ps.last) begin
            walk_phase = PH_DONE;
        end else if (walk_phase == PH_R1) begin
            off_x++;
            grad_x += 2 * ry2;
            if (decision[63]) begin
                decision += 4 * grad_x + 4 * ry2;
            end else begin
                off_y--;
                grad_y -= 2 * rx2;
                decision += 4 * (grad_x - grad_y + ry2);
            end
        end else begin
            off_y--;
            grad_y -= 2 * rx2;
            if (!decision[63] && decision != 0) begin
                decision += 4 * (rx2 - grad_y);
            end else begin
                off_x++;
                grad_x += 2 * ry2;
                decision += 4 * (grad_x - grad_y + rx2);
            end
        end
        return ps;
    endfunction

    // Expected result of one accepted transaction
    function automatic point_set_t trace_ellipse(draw_req_t req);
        point_set_t ps;
        ps = '0;
        if (req.cmd == CMD_START) begin
            hold_rx  = 64'(req.rad_x);
            hold_ry  = 64'(req.rad_y);
            hold_cx  = req.ctr_x;
            hold_cy  = req.ctr_y;
            off_x    = 0;
            off_y    = int'(req.rad_y);
            grad_x   = '0;
            grad_y   = 2 * hold_rx * hold_rx * hold_ry;
            decision = 4 * hold_ry * hold_ry - 4 * hold_rx * hold_rx * hold_ry
                     + hold_rx * hold_rx;
            walk_phase = PH_R1;
            ps = emit_set();
        end else if (walk_phase != PH_DONE) begin
            ps = emit_set();
        end
        return ps;
    endfunction

    task automatic queue_start(int rx, int ry, int cx, int cy);
        draw_req_t req;
        req.cmd   = CMD_START;
        req.rad_x = mer_pkg::RAD_W'(rx);
        req.rad_y = mer_pkg::RAD_W'(ry);
        req.ctr_x = mer_pkg::CRD_W'(cx);
        req.ctr_y = mer_pkg::CRD_W'(cy);
        pending_reqs.push_back(req);
    endtask

    // Steps carry random fields, which the block must ignore
    task automatic queue_steps(int count);
        draw_req_t req;
        repeat (count) begin
            req.cmd   = CMD_STEP;
            req.rad_x = mer_pkg::RAD_W'($urandom);
            req.rad_y = mer_pkg::RAD_W'($urandom);
            req.ctr_x = mer_pkg::CRD_W'($urandom);
            req.ctr_y = mer_pkg::CRD_W'($urandom);
            pending_reqs.push_back(req);
        end
    endtask

    // Input driver: one transaction at a time from the pending queue
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !in_fire)) begin
            if (in_fire)
                in_gap = draw_idle(in_calm);
            if (in_gap > 0) begin
                s_tvalid <= 1'b0;
                in_gap--;
            end else if (pending_reqs.size() > 0) begin
                draw_req_t req;
                req = pending_reqs.pop_front();
                s_tdata  <= {2'b00, req.ctr_y, req.ctr_x, req.rad_y, req.rad_x};
                s_tuser  <= req.cmd;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output backpressure: random stall before each result transaction
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (out_fire)
                out_stall = draw_idle(out_calm);
            if (out_stall > 0) begin
                m_tready <= 1'b0;
                out_stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor: predict on input transactions, check result transactions
    always @(posedge aclk) begin
        in_fire  = aresetn && s_tvalid && s_tready;
        out_fire = aresetn && m_tvalid && m_tready;
        if (in_fire) begin
            draw_req_t req;
            req.cmd   = cmd_t'(s_tuser);
            req.rad_x = s_tdata[10:0];
            req.rad_y = s_tdata[21:11];
            req.ctr_x = s_tdata[33:22];
            req.ctr_y = s_tdata[45:34];
            expected_sets.push_back(trace_ellipse(req));
            n_accepted++;
        end
        if (out_fire) begin
            if (expected_sets.size() == 0) begin
                $error("result transaction with no expected point set");
                n_errors++;
            end else begin
                point_set_t exp_set;
                point_set_t got_set;
                exp_set = expected_sets.pop_front();
                got_set.coord = m_tdata;
                got_set.valid = m_tuser;
                got_set.last  = m_tlast;
                for (int i = 0; i < 8; i++) begin
                    if (got_set.coord[i] !== exp_set.coord[i]) begin
                        $error("%s: expected %0d, got %0d", COORD_NAME[i],
                               $signed(exp_set.coord[i]), $signed(got_set.coord[i]));
                        n_errors++;
                    end
                end
                if (got_set.valid !== exp_set.valid) begin
                    $error("point_valid: expected %0d, got %0d", exp_set.valid,
                           got_set.valid);
                    n_errors++;
                end
                if (got_set.last !== exp_set.last) begin
                    $error("last_set: expected %0d, got %0d", exp_set.last,
                           got_set.last);
                    n_errors++;
                end
            end
        end
    end

    // Stimulus and end of test
    initial begin
        int n_rand;
        int sel, rx, ry, n;
        // Step before any start: all-zero result
        queue_steps(1);
        // Zero x radius: region one skipped, then a step past the end
        queue_start(0, 3, 100, 100);
        queue_steps(4);
        // Zero y radius: single set at the centre flagged last
        queue_start(4, 0, 0, 0);
        queue_steps(1);
        // Largest radii at the top corner: coordinates exceed the 12-bit centre range
        queue_start(2047, 2047, 4095, 4095);
        queue_steps(3);
        // Restart mid-ellipse with a wide flat ellipse at the origin
        queue_start(2047, 1, 0, 0);
        queue_steps(4);
        // Small ellipse run through the region change to the end and beyond
        queue_start(3, 2, 2048, 1);
        queue_steps(7);

        // Random part: mostly whole small ellipses, some cut short, some noise
        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                rx = $urandom_range(0, 24);
                ry = $urandom_range(0, 24);
                n  = rx + ry + $urandom_range(0, 2);
                queue_start(rx, ry, $urandom_range(0, 4095), $urandom_range(0, 4095));
            end else if (sel < 85) begin
                n = $urandom_range(0, 30);
                queue_start($urandom_range(0, 2047), $urandom_range(0, 2047),
                            $urandom_range(0, 4095), $urandom_range(0, 4095));
            end else begin
                n = 0;
                if ($urandom_range(0, 1) == 0)
                    queue_start($urandom_range(0, 2047), $urandom_range(0, 2047),
                                $urandom_range(0, 4095), $urandom_range(0, 4095));
                else
                    queue_steps(1);
            end
            queue_steps(n);
            n_rand += n + 1;
        end
        n_total = pending_reqs.size();

        // Drain: all accepted, all results back, then a short quiet window
        while (n_accepted < n_total) @(posedge aclk);
        while (expected_sets.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (n_errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Timeout
    initial begin
        #5000000;
        $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire
